>>> hdl/twcm_pkg.sv
// Package for the tile window coverage masks unit.
// Request and result types, window store entry, controller commands and status.
// No dependencies.
`default_nettype none

package twcm_pkg;

  localparam int unsigned TileSize   = 64;
  localparam int unsigned MaxTilesX  = 64;
  localparam int unsigned MaxTilesY  = 64;
  localparam int unsigned MaxWindows = 64;
  localparam int unsigned NumEntries = 64;
  localparam int unsigned IdxW       = $clog2(NumEntries);

  localparam logic ActLoad  = 1'b0;
  localparam logic ActQuery = 1'b1;

  localparam logic [1:0] RegDisplayWidth  = 2'd0;
  localparam logic [1:0] RegDisplayHeight = 2'd1;
  localparam logic [1:0] RegWindowCount   = 2'd2;
  localparam logic [1:0] RegCornerRadius  = 2'd3;

  typedef struct packed {
    logic               action;
    logic [5:0]         slot;
    logic signed [15:0] window_x;
    logic signed [15:0] window_y;
    logic [15:0]        outer_width;
    logic [15:0]        outer_height;
    logic               visible;
    logic               client_decorated;
    logic [5:0]         tile_col;
    logic [5:0]         tile_row;
  } twcm_in_t;

  typedef struct packed {
    logic        valid_res;
    logic [63:0] hit_bits;
    logic [63:0] cover_bits;
    logic [63:0] solid_bits;
  } twcm_out_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        w;
    logic [15:0]        h;
    logic               vis;
    logic               cd;
  } twcm_entry_t;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDone
  } twcm_state_e;

  typedef struct packed {
    logic            wr_en;
    logic            qry_start;
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            out_load;
  } twcm_cmd_t;

  typedef struct packed {
    logic            qry_ok;
    logic            wc_zero;
    logic [IdxW-1:0] wc_last;
    logic            cmp_vld;
    logic            out_free;
  } twcm_status_t;

endpackage

`default_nettype wire

>>> hdl/twcm_datapath.sv
// Datapath: configuration registers, window store, per-window coverage compare,
// mask accumulation and result register. Uses twcm_pkg.
`default_nettype none

module twcm_datapath import twcm_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [15:0]  cfg_data_i,
  input  wire twcm_in_t     in_req_i,
  input  wire logic         out_stall_i,
  input  wire twcm_cmd_t    cmd_i,
  output twcm_status_t      st_o,
  output logic              out_valid_o,
  output twcm_out_t         out_res_o
);

  logic [15:0] dw_q, dh_q;
  logic [6:0]  wc_q;
  logic [7:0]  rad_q;

  twcm_entry_t mem_q [NumEntries];
  twcm_entry_t rd_q;
  logic [IdxW-1:0] cmp_idx_q;
  logic cmp_vld_q;

  logic signed [18:0] tl_q, tt_q, tr_q, tb_q;
  logic qry_ok_q;
  logic [63:0] touch_q, full_q, opaque_q;
  logic out_valid_q;
  twcm_out_t out_q;

  logic [17:0] tl_u, tt_u, tr_u, tb_u;
  logic        qry_ok;
  logic signed [18:0] l, t, r, b, w19, h19, rad19;
  logic        present, touch, full, opq_in, opaque;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dw_q  <= '0;
      dh_q  <= '0;
      wc_q  <= '0;
      rad_q <= 8'd8;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegDisplayWidth:  dw_q  <= cfg_data_i;
        RegDisplayHeight: dh_q  <= cfg_data_i;
        RegWindowCount:   wc_q  <= cfg_data_i[6:0];
        RegCornerRadius:  rad_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Window store
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[in_req_i.slot] <= '{x:   in_req_i.window_x,
                                y:   in_req_i.window_y,
                                w:   in_req_i.outer_width,
                                h:   in_req_i.outer_height,
                                vis: in_req_i.visible,
                                cd:  in_req_i.client_decorated};
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
    end else begin
      cmp_vld_q <= cmd_i.rd_en;
      cmp_idx_q <= cmd_i.rd_addr;
    end
  end

  // Tile bounds and query legality
  always_comb begin
    tl_u = 18'(in_req_i.tile_col) * 18'(TileSize);
    tt_u = 18'(in_req_i.tile_row) * 18'(TileSize);
    tr_u = tl_u + 18'(TileSize);
    tb_u = tt_u + 18'(TileSize);
    if (tr_u > {2'b00, dw_q}) tr_u = {2'b00, dw_q};
    if (tb_u > {2'b00, dh_q}) tb_u = {2'b00, dh_q};
    qry_ok = ({1'b0, in_req_i.tile_col} < 7'(MaxTilesX)) &&
             ({1'b0, in_req_i.tile_row} < 7'(MaxTilesY)) &&
             (tl_u < {2'b00, dw_q}) && (tt_u < {2'b00, dh_q}) &&
             (wc_q <= 7'(MaxWindows));
  end

  // Coverage compare on the registered store entry
  always_comb begin
    l     = {{3{rd_q.x[15]}}, rd_q.x};
    t     = {{3{rd_q.y[15]}}, rd_q.y};
    w19   = {3'b000, rd_q.w};
    h19   = {3'b000, rd_q.h};
    rad19 = {11'd0, rad_q};
    r     = l + w19;
    b     = t + h19;
    present = rd_q.vis && (rd_q.w != 16'd0) && (rd_q.h != 16'd0);
    touch = present && (l < tr_q) && (r > tl_q) && (t < tb_q) && (b > tt_q);
    full  = touch && (l <= tl_q) && (t <= tt_q) && (r >= tr_q) && (b >= tb_q);
    opq_in = ({1'b0, rd_q.w} > {8'd0, rad_q, 1'b0}) &&
             ({1'b0, rd_q.h} > {8'd0, rad_q, 1'b0}) &&
             (l + rad19 <= tl_q) && (t + rad19 <= tt_q) &&
             (r - rad19 >= tr_q) && (b - rad19 >= tb_q);
    opaque = touch && (rd_q.cd ? full : opq_in);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.qry_start) begin
      tl_q     <= {1'b0, tl_u};
      tt_q     <= {1'b0, tt_u};
      tr_q     <= {1'b0, tr_u};
      tb_q     <= {1'b0, tb_u};
      qry_ok_q <= qry_ok;
      touch_q  <= '0;
      full_q   <= '0;
      opaque_q <= '0;
    end else if (cmp_vld_q) begin
      touch_q[cmp_idx_q]  <= touch;
      full_q[cmp_idx_q]   <= full;
      opaque_q[cmp_idx_q] <= opaque;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= '{valid_res:  qry_ok_q,
                 hit_bits:   touch_q,
                 cover_bits: full_q,
                 solid_bits: opaque_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  assign st_o.qry_ok   = qry_ok;
  assign st_o.wc_zero  = (wc_q == 7'd0);
  assign st_o.wc_last  = IdxW'(wc_q - 7'd1);
  assign st_o.cmp_vld  = cmp_vld_q;
  assign st_o.out_free = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

>>> hdl/twcm_ctrl.sv
// Controller: accepts loads and queries, sequences store reads over the loaded
// windows, and hands the finished masks to the result register. Uses twcm_pkg.
`default_nettype none

module twcm_ctrl import twcm_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire logic         action_i,
  output logic              in_stall_o,
  input  wire twcm_status_t st_i,
  output twcm_cmd_t         cmd_o
);

  twcm_state_e state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (action_i == ActLoad) begin
            cmd_o.wr_en = 1'b1;
          end else begin
            cmd_o.qry_start = 1'b1;
            cnt_d = '0;
            if (st_i.qry_ok && !st_i.wc_zero) begin
              state_d = StScan;
            end else begin
              state_d = StDone;
            end
          end
        end
      end
      StScan: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = cnt_q;
        if (cnt_q == st_i.wc_last) begin
          state_d = StDone;
        end else begin
          cnt_d = cnt_q + IdxW'(1);
        end
      end
      StDone: begin
        if (!st_i.cmp_vld && st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> st_i.out_free) else $error("result loaded over pending one");
  a_rd_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |=> st_i.cmp_vld) else $error("store read not followed by compare");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (cnt_q <= st_i.wc_last)) else $error("scan past window count");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.qry_start || cmd_o.wr_en) |-> (state_q == StIdle && !st_i.cmp_vld))
    else $error("request taken while busy");
`endif

endmodule

`default_nettype wire

>>> hdl/tile_window_coverage_masks_unit.sv
// Top level of the tile window coverage masks unit.
// Instantiates twcm_ctrl and twcm_datapath; uses twcm_pkg.
//
// Window rectangles are loaded into a 64-entry store by index; a tile query
// tests loaded windows 0..N-1, N being the configured window count, against
// the clipped tile square and returns touch, full and opaque masks. A legal
// query holds the unit from accept through one store read per window over the
// single read port, the compare and the result load; an illegal or empty query
// goes from accept straight to the result load. The result waits in an output
// register, so loads are still taken while it is stalled.
`default_nettype none

module tile_window_coverage_masks_unit import twcm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire twcm_in_t    in_req_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output twcm_out_t        out_res_o
);

  twcm_cmd_t    cmd;
  twcm_status_t st;

  assign cfg_ready_o = 1'b1;

  twcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (in_req_i.action),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  twcm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_req_i    (in_req_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_res_o   (out_res_o)
  );

endmodule

`default_nettype wire
